### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PQE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PQE_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PQE_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define PQE_ASSERT_NXT(name, clk, rst, ante, cons, msg)

`endif

`endif

### hw/rtl/pqe_pkg.sv
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared constants, codes and control structs of the perturbation engine.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int DEF_MAX_RECORD = 4096;
  localparam int DEF_MAX_WINDOW = 11;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int PCT_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int PCT_SCALE   = 100;
  localparam int PCT_SCALE_W = 7;
  localparam int MIN_WINDOW  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

  localparam logic             RESET_MODE   = 1'b1;
  localparam logic [CFG_W-1:0] RESET_WINDOW = 4'd3;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FEW,
    STATUS_ZERO_SUM,
    STATUS_TOO_LONG
  } status_t;

  typedef struct packed {
    logic start;
    logic local_mode;
  } seq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

### hw/rtl/perturbation_quotient_engine.sv
// ----------------------------------------------------------------------------
// perturbation_quotient_engine
// Jitter / shimmer style perturbation measure over a record of values.
// ----------------------------------------------------------------------------
// While a record streams in, one item is taken every clock: the window
// shift line, running sum and accumulators update once per item. After
// the item marked end_of_record the input stalls; state FLUSH settles the
// last centred update and CHECK the status, then, for an ok status, one
// shared adder runs three shift-add products of MB_W steps each and a
// restoring division of Y_W + 16 steps (MB_W = max(CNT_W, 7),
// Y_W = CNT_W + DEV_W + 7). The result is held in the output register until
// taken, and input resumes in the cycle after that.
`include "assert_macros.svh"

module perturbation_quotient_engine #(
  parameter int MAX_RECORD = pqe_pkg::DEF_MAX_RECORD,
  parameter int MAX_WINDOW = pqe_pkg::DEF_MAX_WINDOW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pqe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pqe_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pqe_pkg::SAMPLE_W-1:0]   sample_value,
  input  logic                           end_of_record,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pqe_pkg::PCT_W-1:0]      percent_value,
  output logic [1:0]                     result_status
);

  localparam int CNT_W  = $clog2(MAX_RECORD + 2);
  localparam int WSUM_W = pqe_pkg::SAMPLE_W + $clog2(MAX_WINDOW + 1);
  localparam int VAL_W  = pqe_pkg::SAMPLE_W + $clog2(MAX_RECORD + 1);
  localparam int DEV_W  = VAL_W + WSUM_W - pqe_pkg::SAMPLE_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RECORD);

  typedef enum logic [2:0] {
    ACCEPT,
    FLUSH,
    CHECK,
    CALC,
    HOLD
  } state_t;

  state_t                      state;
  logic                        measure_mode;
  logic [pqe_pkg::CFG_W-1:0]   window_size;

  logic                        take;
  logic                        clear;
  logic [CNT_W-1:0]            count;
  logic [DEV_W-1:0]            dev_sum;
  logic [VAL_W-1:0]            val_sum;
  logic                        rec_mode;
  logic [pqe_pkg::CFG_W-1:0]   rec_win;
  pqe_pkg::status_t            status;
  pqe_pkg::seq_ctrl_t          seq_ctrl;
  pqe_pkg::seq_stat_t          seq_stat;
  logic [pqe_pkg::PCT_W-1:0]   seq_pct;

  assign take      = in_valid && !in_stall;
  assign in_stall  = (state != ACCEPT);
  assign out_valid = (state == HOLD);

  always_comb begin
    priority if (count > CNT_LIMIT) begin
      status = pqe_pkg::STATUS_TOO_LONG;
    end else if ((!rec_mode && count < CNT_W'(2)) || (rec_mode && count < CNT_W'(rec_win))) begin
      status = pqe_pkg::STATUS_FEW;
    end else if (val_sum == '0) begin
      status = pqe_pkg::STATUS_ZERO_SUM;
    end else begin
      status = pqe_pkg::STATUS_OK;
    end
    seq_ctrl.start      = (state == CHECK) && (status == pqe_pkg::STATUS_OK);
    seq_ctrl.local_mode = !rec_mode;
    clear = ((state == CHECK) && (status != pqe_pkg::STATUS_OK))
         || ((state == CALC) && seq_stat.done);
  end

  pqe_accum #(
    .MAX_RECORD(MAX_RECORD),
    .MAX_WINDOW(MAX_WINDOW),
    .CNT_W     (CNT_W),
    .WSUM_W    (WSUM_W),
    .VAL_W     (VAL_W),
    .DEV_W     (DEV_W)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .sample_value(sample_value),
    .cfg_mode    (measure_mode),
    .cfg_window  (window_size),
    .clear       (clear),
    .count       (count),
    .dev_sum     (dev_sum),
    .val_sum     (val_sum),
    .rec_mode    (rec_mode),
    .rec_win     (rec_win)
  );

  pqe_seq #(
    .CNT_W(CNT_W),
    .VAL_W(VAL_W),
    .DEV_W(DEV_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (seq_ctrl),
    .count  (count),
    .win    (rec_win),
    .dev_sum(dev_sum),
    .val_sum(val_sum),
    .stat   (seq_stat),
    .pct    (seq_pct)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ACCEPT;
      measure_mode <= pqe_pkg::RESET_MODE;
      window_size  <= pqe_pkg::RESET_WINDOW;
    end else begin
      if (cfg_write) begin
        priority if (cfg_index == pqe_pkg::REG_MODE) begin
          measure_mode <= cfg_data[0];
        end else if (cfg_index == pqe_pkg::REG_WINDOW) begin
          window_size <= cfg_data;
        end
      end
      unique case (state)
        ACCEPT: begin
          if (take && end_of_record) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          state <= CHECK;
        end
        CHECK: begin
          if (status == pqe_pkg::STATUS_OK) begin
            state <= CALC;
          end else begin
            percent_value <= '0;
            result_status <= status;
            state         <= HOLD;
          end
        end
        CALC: begin
          if (seq_stat.done) begin
            percent_value <= seq_pct;
            result_status <= pqe_pkg::STATUS_OK;
            state         <= HOLD;
          end
        end
        HOLD: begin
          if (!out_stall) begin
            state <= ACCEPT;
          end
        end
        default: begin
          state <= ACCEPT;
        end
      endcase
    end
  end

  `PQE_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && result_status != pqe_pkg::STATUS_OK, percent_value == '0, "failed result with nonzero percent")
  `PQE_ASSERT_NXT(a_last_stalls, clk, rst, take && end_of_record, in_stall && !out_valid, "input open after last item")
  `PQE_ASSERT_IMP(a_done_in_calc, clk, rst, seq_stat.done, state == CALC, "sequencer done outside calc")
  `PQE_ASSERT_IMP(a_calc_busy, clk, rst, state == CALC, seq_stat.busy || seq_stat.done, "calc with idle sequencer")

endmodule

### hw/rtl/pqe_alu.sv
// ----------------------------------------------------------------------------
// pqe_alu
// Shared adder / subtractor; carry out is a >= b when subtracting.
// ----------------------------------------------------------------------------
module pqe_alu #(
  parameter int W = pqe_pkg::PCT_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] total;

  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W + 1)'(sub);
  assign sum   = total[W-1:0];
  assign carry = total[W];

endmodule

### hw/rtl/pqe_accum.sv
// ----------------------------------------------------------------------------
// pqe_accum
// Per-item front end: window shift line, running window sum, item count
// and the deviation and value accumulators of one record.
// ----------------------------------------------------------------------------
module pqe_accum #(
  parameter int MAX_RECORD = pqe_pkg::DEF_MAX_RECORD,
  parameter int MAX_WINDOW = pqe_pkg::DEF_MAX_WINDOW,
  parameter int CNT_W      = $clog2(MAX_RECORD + 2),
  parameter int WSUM_W     = pqe_pkg::SAMPLE_W + $clog2(MAX_WINDOW + 1),
  parameter int VAL_W      = pqe_pkg::SAMPLE_W + $clog2(MAX_RECORD + 1),
  parameter int DEV_W      = VAL_W + WSUM_W - pqe_pkg::SAMPLE_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [pqe_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                        cfg_mode,
  input  logic [pqe_pkg::CFG_W-1:0]   cfg_window,
  input  logic                        clear,
  output logic [CNT_W-1:0]            count,
  output logic [DEV_W-1:0]            dev_sum,
  output logic [VAL_W-1:0]            val_sum,
  output logic                        rec_mode,
  output logic [pqe_pkg::CFG_W-1:0]   rec_win
);

  localparam int SW    = pqe_pkg::SAMPLE_W;
  localparam int CW    = pqe_pkg::CFG_W;
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [CW-1:0]    WIN_TOP   = CW'((MAX_WINDOW - 1) | 1);
  localparam logic [CW-1:0]    WIN_MIN   = CW'(pqe_pkg::MIN_WINDOW);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RECORD);
  localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_RECORD + 1);

  logic [SW-1:0]     store [MAX_WINDOW];
  logic [WSUM_W-1:0] run_sum;
  logic              pend;

  logic              first;
  logic              room;
  logic              mode_cur;
  logic [CW-1:0]     win_odd;
  logic [CW-1:0]     win_eff;
  logic [CW-1:0]     win_cur;
  logic [CW-1:0]     leave_idx;
  logic [CW-1:0]     ctr_idx;
  logic [CNT_W-1:0]  cnt_inc;
  logic [WSUM_W-1:0] run_sum_next;
  logic [SW-1:0]     step_abs;
  logic [SW-1:0]     center;
  logic [SW+CW-1:0]  cw_full;
  logic [WSUM_W-1:0] cw;
  logic [WSUM_W-1:0] dev_q;

  always_comb begin
    win_odd = cfg_window | CW'(1);
    win_eff = win_odd;
    if (win_odd < WIN_MIN) begin
      win_eff = WIN_MIN;
    end
    if (win_odd > WIN_TOP) begin
      win_eff = WIN_TOP;
    end
    first        = (count == '0);
    room         = (count < CNT_LIMIT);
    mode_cur     = first ? cfg_mode : rec_mode;
    win_cur      = first ? win_eff : rec_win;
    cnt_inc      = count + CNT_W'(1);
    leave_idx    = win_cur - CW'(1);
    run_sum_next = run_sum + WSUM_W'(sample_value) - WSUM_W'(store[leave_idx[IDX_W-1:0]]);
    step_abs     = (sample_value >= store[0]) ? sample_value - store[0]
                                              : store[0] - sample_value;
    ctr_idx      = rec_win >> 1;
    center       = store[ctr_idx[IDX_W-1:0]];
    cw_full      = (SW + CW)'(center) * (SW + CW)'(rec_win);
    cw           = cw_full[WSUM_W-1:0];
    dev_q        = (cw >= run_sum) ? cw - run_sum : run_sum - cw;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        store[i] <= '0;
      end
      run_sum  <= '0;
      count    <= '0;
      dev_sum  <= '0;
      val_sum  <= '0;
      rec_mode <= 1'b0;
      rec_win  <= WIN_MIN;
      pend     <= 1'b0;
    end else begin
      // centred update of quotient mode, made in the cycle after the item
      pend <= take && room && mode_cur && (cnt_inc >= CNT_W'(win_cur));
      if (pend) begin
        dev_sum <= dev_sum + DEV_W'(dev_q);
        val_sum <= val_sum + VAL_W'(center);
      end else if (take && room && !mode_cur) begin
        if (!first) begin
          dev_sum <= dev_sum + DEV_W'(step_abs);
        end
        val_sum <= val_sum + VAL_W'(sample_value);
      end
      if (take) begin
        if (first) begin
          rec_mode <= cfg_mode;
          rec_win  <= win_eff;
        end
        if (room) begin
          run_sum <= run_sum_next;
          for (int i = MAX_WINDOW - 1; i > 0; i--) begin
            store[i] <= store[i-1];
          end
          store[0] <= sample_value;
          count    <= cnt_inc;
        end else begin
          count <= CNT_OVER;
        end
      end
    end
  end

endmodule

### hw/rtl/pqe_seq.sv
// ----------------------------------------------------------------------------
// pqe_seq
// End-of-record sequencer: shift-add products and a restoring division,
// all on one shared adder, giving the saturated Q16.16 percent.
// ----------------------------------------------------------------------------
module pqe_seq #(
  parameter int CNT_W = 13,
  parameter int VAL_W = 29,
  parameter int DEV_W = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pqe_pkg::seq_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]           count,
  input  logic [pqe_pkg::CFG_W-1:0]  win,
  input  logic [DEV_W-1:0]           dev_sum,
  input  logic [VAL_W-1:0]           val_sum,
  output pqe_pkg::seq_stat_t         stat,
  output logic [pqe_pkg::PCT_W-1:0]  pct
);

  localparam int PW    = pqe_pkg::PCT_W;
  localparam int MB_W  = (CNT_W > pqe_pkg::PCT_SCALE_W) ? CNT_W : pqe_pkg::PCT_SCALE_W;
  localparam int NUM_W = CNT_W + DEV_W;
  localparam int Y_W   = NUM_W + pqe_pkg::PCT_SCALE_W;
  localparam int DEN_W = MB_W + VAL_W;
  localparam int DVD_W = Y_W + pqe_pkg::FRAC_W;
  localparam int ALU_W = (Y_W > DEN_W) ? Y_W : DEN_W + 1;
  localparam int CTR_W = $clog2(DVD_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_NUM,
    S_MUL_PCT,
    S_MUL_DEN,
    S_DIV
  } state_t;

  state_t           state;
  logic             loc;
  logic [ALU_W-1:0] prod;
  logic [ALU_W-1:0] mcand;
  logic [MB_W-1:0]  mplier;
  logic [Y_W-1:0]   y;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [PW-1:0]    quo;
  logic             ovf;
  logic [CTR_W-1:0] ctr;
  logic             done;

  logic [DEN_W:0]   rs_div;
  logic [CNT_W-1:0] cnt_less;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W-1:0] alu_sum;
  logic             alu_carry;

  always_comb begin
    rs_div   = {rem, dvd[DVD_W-1]};
    cnt_less = count - CNT_W'(1);
    if (state == S_DIV) begin
      alu_a   = ALU_W'(rs_div);
      alu_b   = ALU_W'(den);
      alu_sub = 1'b1;
    end else begin
      alu_a   = {prod[ALU_W-2:0], 1'b0};
      alu_b   = mplier[MB_W-1] ? mcand : '0;
      alu_sub = 1'b0;
    end
  end

  pqe_alu #(
    .W(ALU_W)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .carry(alu_carry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DIV) && (ctr == '0);
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            loc    <= ctrl.local_mode;
            mcand  <= ALU_W'(dev_sum);
            mplier <= ctrl.local_mode ? MB_W'(count) : MB_W'(1);
            prod   <= '0;
            ctr    <= CTR_W'(MB_W - 1);
            state  <= S_MUL_NUM;
          end
        end
        S_MUL_NUM: begin
          if (ctr == '0) begin
            mcand  <= ALU_W'(alu_sum[NUM_W-1:0]);
            mplier <= MB_W'(pqe_pkg::PCT_SCALE);
            prod   <= '0;
            ctr    <= CTR_W'(MB_W - 1);
            state  <= S_MUL_PCT;
          end else begin
            prod   <= alu_sum;
            mplier <= {mplier[MB_W-2:0], 1'b0};
            ctr    <= ctr - CTR_W'(1);
          end
        end
        S_MUL_PCT: begin
          if (ctr == '0) begin
            y      <= alu_sum[Y_W-1:0];
            mcand  <= ALU_W'(val_sum);
            mplier <= loc ? MB_W'(cnt_less) : MB_W'(win);
            prod   <= '0;
            ctr    <= CTR_W'(MB_W - 1);
            state  <= S_MUL_DEN;
          end else begin
            prod   <= alu_sum;
            mplier <= {mplier[MB_W-2:0], 1'b0};
            ctr    <= ctr - CTR_W'(1);
          end
        end
        S_MUL_DEN: begin
          if (ctr == '0) begin
            den   <= alu_sum[DEN_W-1:0];
            rem   <= '0;
            quo   <= '0;
            ovf   <= 1'b0;
            dvd   <= {y, pqe_pkg::FRAC_W'(0)};
            ctr   <= CTR_W'(DVD_W - 1);
            state <= S_DIV;
          end else begin
            prod   <= alu_sum;
            mplier <= {mplier[MB_W-2:0], 1'b0};
            ctr    <= ctr - CTR_W'(1);
          end
        end
        S_DIV: begin
          rem <= alu_carry ? alu_sum[DEN_W-1:0] : rs_div[DEN_W-1:0];
          quo <= {quo[PW-2:0], alu_carry};
          ovf <= ovf | quo[PW-1];
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          if (ctr == '0) begin
            state <= S_IDLE;
          end else begin
            ctr <= ctr - CTR_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pct       = ovf ? '1 : quo;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule
